### sv/dq_pkg.sv
// Shared types, codes and constants for the double-ended queue.
package dq_pkg;

    localparam int WORD_W        = 32;
    localparam int COUNT_OUT_W   = 8;
    localparam int DEPTH_DEFAULT = 128;

    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [WORD_W-1:0] push_value;
    } in_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [WORD_W-1:0]  removed_value;
        logic signed [WORD_W-1:0]  front_value;
        logic signed [WORD_W-1:0]  back_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
    } out_t;

    typedef struct packed {
        logic accept;
        logic fill;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_stat_t;

endpackage

### sv/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
//
//  channel | signals                       | moves
//  --------+-------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data   | one operation item (func, value)
//  out     | out_valid, out_ready, out_data| one result item per input item
//
// Pushes, queries, failed operations and pops that empty the queue register their
// result directly. A pop that leaves words behind adds a fill state: the new end word
// is fetched through the store's registered read port.
// Reset clears the pointers and count only; the word store is not cleared.
// in_ready drops while a result waits untaken or during the end-word fetch.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dq_pkg::in_t   in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dq_pkg::out_t  out_data
);
    import dq_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

### sv/dq_ctrl.sv
// Controller: handshake, item sequencing and output valid.
module dq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dq_pkg::dp_stat_t   stat,
    output dq_pkg::ctl_cmd_t   cmd
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign cmd.accept = accept;
    assign cmd.fill   = (state_reg == S_FILL);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.need_read)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((accept && !stat.need_read) || (state_reg == S_FILL))
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/dq_datapath.sv
// Datapath: word store, end pointers, cached end words and result register.
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dq_pkg::in_t        in_data,
    input  dq_pkg::ctl_cmd_t   cmd,
    output dq_pkg::dp_stat_t   stat,
    output dq_pkg::out_t       out_data
);
    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [WORD_W-1:0] front_reg, front_next;
    logic signed [WORD_W-1:0] back_reg, back_next;
    logic signed [WORD_W-1:0] rdata_reg;
    logic signed [WORD_W-1:0] removed_reg;
    logic                     pend_front_reg;
    out_t                     out_reg;

    logic                     we, re, pop_at_front;
    logic [IW-1:0]            waddr, raddr;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] removed;
    logic                     empty_now, full_now;
    out_t                     result;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
        ptr_dec = (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CW-1:0] c);
        logic [CW+COUNT_OUT_W-1:0] wide;
        wide      = {{COUNT_OUT_W{1'b0}}, c};
        count_out = wide[COUNT_OUT_W-1:0];
    endfunction

    assign empty_now = (count_reg == '0);
    assign full_now  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        status       = ST_OK;
        removed      = '0;
        we           = 1'b0;
        re           = 1'b0;
        pop_at_front = 1'b0;
        waddr        = ptr_dec(head_reg);
        raddr        = ptr_inc(head_reg);
        case (in_data.func)
            FN_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    head_next  = ptr_dec(head_reg);
                    waddr      = head_next;
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    front_next = in_data.push_value;
                    if (empty_now)
                    begin
                        back_next = in_data.push_value;
                    end
                end
            end
            FN_PUSH_BACK:
            begin
                if (full_now)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    tail_next  = ptr_inc(tail_reg);
                    waddr      = tail_next;
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    back_next  = in_data.push_value;
                    if (empty_now)
                    begin
                        front_next = in_data.push_value;
                    end
                end
            end
            FN_POP_FRONT:
            begin
                if (empty_now)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    removed      = front_reg;
                    head_next    = ptr_inc(head_reg);
                    raddr        = head_next;
                    count_next   = count_reg - 1'b1;
                    pop_at_front = 1'b1;
                    // new front word comes from the store unless this empties it
                    re           = (count_next != '0);
                end
            end
            FN_POP_BACK:
            begin
                if (empty_now)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    removed    = back_reg;
                    tail_next  = ptr_dec(tail_reg);
                    raddr      = tail_next;
                    count_next = count_reg - 1'b1;
                    re         = (count_next != '0);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign stat.need_read = re;

    always_comb
    begin
        result = out_reg;
        if (cmd.fill)
        begin
            result.status        = ST_OK;
            result.removed_value = removed_reg;
            result.front_value   = pend_front_reg ? rdata_reg : front_reg;
            result.back_value    = pend_front_reg ? back_reg : rdata_reg;
            result.entry_count   = count_out(count_reg);
            result.is_empty      = 1'b0;
        end
        else
        begin
            result.status        = status;
            result.removed_value = removed;
            result.front_value   = (count_next == '0) ? EMPTY_WORD : front_next;
            result.back_value    = (count_next == '0) ? EMPTY_WORD : back_next;
            result.entry_count   = count_out(count_next);
            result.is_empty      = (count_next == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && we)
        begin
            mem[waddr] <= in_data.push_value;
        end
        if (cmd.accept && re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= IW'(DEPTH - 1);
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            removed_reg    <= removed;
            pend_front_reg <= pop_at_front;
            if (!re)
            begin
                out_reg <= result;
            end
        end
        else if (cmd.fill)
        begin
            if (pend_front_reg)
            begin
                front_reg <= rdata_reg;
            end
            else
            begin
                back_reg <= rdata_reg;
            end
            out_reg <= result;
        end
    end

    assign out_data = out_reg;

endmodule

### sim/tb_double_ended_queue.sv
// Testbench for double_ended_queue: random and directed deque traffic checked against a predictor.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int PHASE_ITEMS = 610;

    localparam logic [2:0] FN_QUERY        = 3'd4;
    localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FN_UNUSED_MID   = 3'd6;
    localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic in_fire = 1'b0;

    in_t  op_pending[$];
    out_t result_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int results_seen = 0;
    int overflow_seen = 0;
    int underflow_seen = 0;
    int peak_fill = 0;

    // predictor state
    logic [WORD_W-1:0] deque_words[DEPTH];
    int deque_head = 0;
    int deque_count = 0;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic out_t deque_apply(in_t item);
        out_t r;
        int back;
        r = '0;
        r.status = ST_OK;
        case (item.func)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (deque_count >= DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                    overflow_seen++;
                end
                else if (item.func == FN_PUSH_FRONT)
                begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_words[deque_head] = item.push_value;
                    deque_count++;
                end
                else
                begin
                    deque_words[(deque_head + deque_count) % DEPTH] = item.push_value;
                    deque_count++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK:
            begin
                if (deque_count == 0)
                begin
                    r.status = ST_UNDERFLOW;
                    underflow_seen++;
                end
                else if (item.func == FN_POP_FRONT)
                begin
                    r.removed_value = deque_words[deque_head];
                    deque_head = (deque_head + 1) % DEPTH;
                    deque_count--;
                end
                else
                begin
                    r.removed_value = deque_words[(deque_head + deque_count - 1) % DEPTH];
                    deque_count--;
                end
            end
            default:
            begin
                // query and unused codes leave the state alone
            end
        endcase
        if (deque_count > peak_fill)
            peak_fill = deque_count;
        if (deque_count == 0)
        begin
            r.front_value = EMPTY_WORD;
            r.back_value  = EMPTY_WORD;
            r.is_empty    = 1'b1;
        end
        else
        begin
            back = (deque_head + deque_count - 1) % DEPTH;
            r.front_value = deque_words[deque_head];
            r.back_value  = deque_words[back];
            r.is_empty    = 1'b0;
        end
        r.entry_count = deque_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        fail_count++;
        $display("[%0t] result %0d %s: got %h, expected %h", $time, results_seen, what, got,
                 want);
    endtask

    task automatic check_result(out_t got, out_t want);
        if (got.status !== want.status)
            report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
        if (got.removed_value !== want.removed_value)
            report_mismatch("removed_value", got.removed_value, want.removed_value);
        if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
        if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", WORD_W'(got.entry_count), WORD_W'(want.entry_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
    endtask

    // driver: new item or idle at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (op_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= op_pending[0];
                    in_valid <= 1'b1;
                    op_pending.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        out_t want;
        out_t pred;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pred = deque_apply(in_data);
                result_q = {result_q, pred};
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (result_q.size() == 0)
                    report_mismatch("unexpected result", WORD_W'(out_data.status), '0);
                else
                begin
                    want = result_q[0];
                    result_q.delete(0);
                    check_result(out_data, want);
                end
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t rand_item(int push_pct, int pop_pct);
        in_t it;
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            it.func = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            it.func = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
        else
            it.func = 3'($urandom_range(FN_UNUSED_LAST, FN_QUERY));
        it.push_value = rand_word();
        return it;
    endfunction

    function automatic void add_pending(in_t it);
        op_pending = {op_pending, it};
    endfunction

    task automatic queue_op(logic [2:0] f, logic [WORD_W-1:0] v);
        in_t it;
        it.func = f;
        it.push_value = v;
        add_pending(it);
    endtask

    task automatic queue_phase(int n_items);
        int left;
        int seg;
        int push_pct;
        int pop_pct;
        // fill past full, then drain past empty, so both error paths are hit
        for (int i = 0; i < DEPTH + 6; i++)
            add_pending(rand_item(100, 0));
        for (int i = 0; i < DEPTH + 6; i++)
            add_pending(rand_item(0, 100));
        left = n_items - 2 * (DEPTH + 6);
        while (left > 0)
        begin
            case ($urandom_range(3))
                0: begin push_pct = 70; pop_pct = 20; end
                1: begin push_pct = 20; pop_pct = 70; end
                2: begin push_pct = 45; pop_pct = 45; end
                default: begin push_pct = 10; pop_pct = 10; end
            endcase
            seg = $urandom_range(120, 20);
            if (seg > left)
                seg = left;
            for (int i = 0; i < seg; i++)
                add_pending(rand_item(push_pct, pop_pct));
            left -= seg;
        end
    endtask

    task automatic wait_drained();
        while (op_pending.size() != 0 || in_valid || result_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 51;
        // empty store, wrap at head 0, word extremes, unused codes, pop to empty
        queue_op(FN_QUERY, '0);
        queue_op(FN_POP_FRONT, '1);
        queue_op(FN_POP_BACK, 32'h1234_5678);
        queue_op(FN_PUSH_FRONT, 32'h7fff_ffff);
        queue_op(FN_PUSH_BACK, 32'h8000_0000);
        queue_op(FN_PUSH_FRONT, '0);
        queue_op(FN_PUSH_BACK, '1);
        queue_op(FN_UNUSED_FIRST, 32'hdead_beef);
        queue_op(FN_UNUSED_MID, '1);
        queue_op(FN_UNUSED_LAST, '0);
        queue_op(FN_POP_BACK, '0);
        queue_op(FN_POP_FRONT, '0);
        queue_op(FN_POP_FRONT, '0);
        queue_op(FN_POP_BACK, '0);
        queue_op(FN_PUSH_BACK, 32'h5555_5555);
        queue_op(FN_PUSH_FRONT, 32'haaaa_aaaa);
        queue_op(FN_QUERY, '1);
        queue_op(FN_POP_FRONT, '0);
        queue_op(FN_POP_FRONT, '0);
        queue_op(FN_POP_BACK, '0);
        wait_drained();

        queue_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 23;
        queue_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phase(PHASE_ITEMS);
        wait_drained();

        repeat (8) @(negedge clk);
        if (result_q.size() != 0)
        begin
            fail_count += result_q.size();
            $display("%0d expected results never arrived", result_q.size());
        end
        $display("Checked %0d results over three stall patterns plus directed corner items;",
                 results_seen);
        $display("saw %0d overflows, %0d underflows, peak occupancy %0d of %0d.",
                 overflow_seen, underflow_seen, peak_fill, DEPTH);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout: results still outstanding at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
